// ----- hw/rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer to ASCII formatter
// Command codes, character codes, the conversion job record and the
// digit-to-character mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned MIN_WIDTH_W = 4;
	localparam int unsigned COUNT_W     = 4;

	// decimal digits needed for any 32-bit magnitude
	localparam int unsigned BCD_DIGITS  = 10;
	localparam int unsigned HEX_NIBBLES = VALUE_W / DIGIT_W;
	localparam int unsigned STORE_W     = BCD_DIGITS * DIGIT_W;

	// caps on the requested minimum width
	localparam int unsigned DEC_DIGITS  = 10;
	localparam int unsigned HEX_DIGITS  = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_UDEC      = 2'd0,
		CMD_SDEC      = 2'd1,
		CMD_HEX_LOWER = 2'd2,
		CMD_HEX_UPPER = 2'd3
	} cmd_t;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

	typedef logic [STORE_W-1:0] store_t;

	// one converted number, digits left-aligned, most significant on top
	typedef struct packed {
		store_t                   digits;
		logic [COUNT_W-1:0]       count;
		logic [MIN_WIDTH_W-1:0]   pads;
		logic                     minus;
		logic                     zero_pad;
		logic                     upper;
	} job_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < 4'd10) begin
			return CHAR_ZERO + {4'd0, d};
		end
		return base + {4'd0, d} - 8'd10;
	endfunction

endpackage

// ----- hw/rtl/itoa_if.sv -----
// ----------------------------------------------------------------------------
// itoa_if: channel interfaces of the integer to ASCII formatter
// Number channel into the block and character channel out of it.
// ----------------------------------------------------------------------------
interface itoa_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [itoa_pkg::CMD_W-1:0]           cmd;
	logic [itoa_pkg::VALUE_W-1:0]         number;
	logic                                 zero_pad;
	logic [itoa_pkg::MIN_WIDTH_W-1:0]     min_width;

	modport source (output valid, cmd, number, zero_pad, min_width, input ready);
	modport sink   (input valid, cmd, number, zero_pad, min_width, output ready);
endinterface

interface itoa_text_if;
	logic                                 valid;
	logic                                 ready;
	logic [itoa_pkg::CHAR_W-1:0]          out_char;
	logic                                 last;

	modport source (output valid, out_char, last, input ready);
	modport sink   (input valid, out_char, last, output ready);
endinterface

// ----- hw/rtl/itoa_conv.sv -----
// ----------------------------------------------------------------------------
// itoa_conv: binary to digit converter
// Shift-and-add-3 conversion one bit per cycle for decimal, direct nibble
// load for hex, then a leading-zero trim one digit per cycle.
// ----------------------------------------------------------------------------
module itoa_conv #(
	parameter int unsigned DEC_DIGITS = itoa_pkg::DEC_DIGITS,
	parameter int unsigned HEX_DIGITS = itoa_pkg::HEX_DIGITS
) (
	input  logic           clk,
	input  logic           arst_n,
	itoa_item_if.sink      item,
	output itoa_pkg::job_t job,
	output logic           job_valid,
	input  logic           job_ready
);

	localparam int unsigned BIT_W = $clog2(itoa_pkg::VALUE_W);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(itoa_pkg::VALUE_W - 1);
	localparam logic [4:0] DEC_CAP = 5'(DEC_DIGITS);
	localparam logic [4:0] HEX_CAP = 5'(HEX_DIGITS);
	localparam int unsigned PAD_W = itoa_pkg::STORE_W - itoa_pkg::VALUE_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DABBLE = 4'b0010,
		ST_TRIM   = 4'b0100,
		ST_DONE   = 4'b1000
	} conv_state_t;

	conv_state_t                          state_q;
	logic [itoa_pkg::VALUE_W-1:0]         bin_q;
	itoa_pkg::store_t                     store_q;
	logic [itoa_pkg::COUNT_W-1:0]         cnt_q;
	logic [BIT_W-1:0]                     bit_q;
	logic [itoa_pkg::MIN_WIDTH_W-1:0]     width_q;
	logic                                 minus_q;
	logic                                 zpad_q;
	logic                                 upper_q;

	itoa_pkg::store_t                     adj;
	logic                                 hex;
	logic                                 neg;
	logic [itoa_pkg::VALUE_W-1:0]         mag;
	logic [4:0]                           cap;
	logic [itoa_pkg::MIN_WIDTH_W-1:0]     capped;

	assign hex = (item.cmd == itoa_pkg::CMD_HEX_LOWER) || (item.cmd == itoa_pkg::CMD_HEX_UPPER);
	assign neg = (item.cmd == itoa_pkg::CMD_SDEC) && item.number[itoa_pkg::VALUE_W-1];
	assign mag = neg ? (~item.number + 1'b1) : item.number;
	assign cap = hex ? HEX_CAP : DEC_CAP;
	assign capped = ({1'b0, item.min_width} > cap) ? cap[itoa_pkg::MIN_WIDTH_W-1:0]
		: item.min_width;

	// add 3 to every BCD digit of 5 or more before the next shift
	always_comb begin
		for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
			adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
				(store_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] >= 4'd5)
				? store_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] + 4'd3
				: store_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign job_valid  = (state_q == ST_DONE);

	always_comb begin
		job.digits   = store_q;
		job.count    = cnt_q;
		job.pads     = (width_q > cnt_q) ? (width_q - cnt_q) : '0;
		job.minus    = minus_q;
		job.zero_pad = zpad_q;
		job.upper    = upper_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= hex ? ST_TRIM : ST_DABBLE;
					end
				end
				ST_DABBLE: begin
					if (bit_q == LAST_BIT) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (!(cnt_q > 4'd1 && store_q[itoa_pkg::STORE_W-1 -: itoa_pkg::DIGIT_W]
						== '0)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (job_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					width_q <= capped;
					minus_q <= neg;
					zpad_q  <= item.zero_pad;
					upper_q <= (item.cmd == itoa_pkg::CMD_HEX_UPPER);
					bin_q   <= mag;
					bit_q   <= '0;
					if (hex) begin
						store_q <= {item.number, {PAD_W{1'b0}}};
						cnt_q   <= itoa_pkg::COUNT_W'(itoa_pkg::HEX_NIBBLES);
					end else begin
						store_q <= '0;
						cnt_q   <= itoa_pkg::COUNT_W'(itoa_pkg::BCD_DIGITS);
					end
				end
			end
			ST_DABBLE: begin
				store_q <= {adj[itoa_pkg::STORE_W-2:0], bin_q[itoa_pkg::VALUE_W-1]};
				bin_q   <= bin_q << 1;
				bit_q   <= bit_q + 1'b1;
			end
			ST_TRIM: begin
				// drop one leading zero digit, keep at least one
				if (cnt_q > 4'd1 && store_q[itoa_pkg::STORE_W-1 -: itoa_pkg::DIGIT_W] == '0)
				begin
					store_q <= store_q << itoa_pkg::DIGIT_W;
					cnt_q   <= cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/itoa_emit.sv -----
// ----------------------------------------------------------------------------
// itoa_emit: character sequencer
// Sends sign, padding and digits one character per cycle while the text
// channel is not stalled, through a registered output slot.
// ----------------------------------------------------------------------------
module itoa_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  itoa_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_ready,
	itoa_text_if.source    text
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SIGN  = 4'b0010,
		ST_PAD   = 4'b0100,
		ST_DIGIT = 4'b1000
	} emit_state_t;

	emit_state_t                          state_q;
	itoa_pkg::store_t                     digits_q;
	logic [itoa_pkg::COUNT_W-1:0]         cnt_q;
	logic [itoa_pkg::MIN_WIDTH_W-1:0]     pads_q;
	logic                                 zpad_q;
	logic                                 upper_q;
	logic                                 valid_q;
	logic [itoa_pkg::CHAR_W-1:0]          char_q;
	logic                                 last_q;
	logic                                 slot_free;
	logic                                 emit_fire;

	assign slot_free     = !valid_q || text.ready;
	// load a new character into the output slot
	assign emit_fire     = slot_free && (state_q != ST_IDLE);
	assign job_ready     = (state_q == ST_IDLE);
	assign text.valid    = valid_q;
	assign text.out_char = char_q;
	assign text.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				valid_q <= 1'b1;
			end else if (text.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= job.minus ? ST_SIGN : ((job.pads != '0) ? ST_PAD : ST_DIGIT);
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= (pads_q != '0) ? ST_PAD : ST_DIGIT;
					end
				end
				ST_PAD: begin
					if (slot_free) begin
						if (pads_q == 4'd1) begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_DIGIT: begin
					if (slot_free) begin
						if (cnt_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					digits_q <= job.digits;
					cnt_q    <= job.count;
					pads_q   <= job.pads;
					zpad_q   <= job.zero_pad;
					upper_q  <= job.upper;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					char_q <= itoa_pkg::CHAR_MINUS;
					last_q <= 1'b0;
				end
			end
			ST_PAD: begin
				if (slot_free) begin
					char_q <= zpad_q ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_SPACE;
					last_q <= 1'b0;
					pads_q <= pads_q - 1'b1;
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					char_q   <= itoa_pkg::digit_char(
						digits_q[itoa_pkg::STORE_W-1 -: itoa_pkg::DIGIT_W], upper_q);
					last_q   <= (cnt_q == 4'd1);
					digits_q <= digits_q << itoa_pkg::DIGIT_W;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/integer_to_ascii_formatter_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: 32-bit value to ASCII text
// Formats a value as unsigned decimal, signed decimal or hex with a minimum
// digit width and zero or space padding, one character per transaction.
// ----------------------------------------------------------------------------
//
//  channel  role  payload                                  transaction
//  -------  ----  ---------------------------------------  -----------------
//  item     sink  cmd[1:0] number[31:0] zero_pad min_width  one number
//  text     src   out_char[7:0] last                        one character
//
// Decimal numbers go through shift-and-add-3 in the converter, hex numbers
// skip it; the trim then drops leading zero digits (up to 9 for decimal,
// up to 7 for hex) and keeps at least one. The sequencer sends one
// character per cycle while the text channel is not stalled (up to 11 per
// number) and overlaps with the conversion of the next number.
// Reset clears both state machines and the output valid flag.
// A stalled text channel holds the current character and pauses the
// sequencer; the converter then holds its finished job and item.ready low.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
	parameter int unsigned DEC_DIGITS = itoa_pkg::DEC_DIGITS,
	parameter int unsigned HEX_DIGITS = itoa_pkg::HEX_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	itoa_item_if.sink   item,
	itoa_text_if.source text
);

	// converted job handed from the converter to the sequencer
	itoa_pkg::job_t job;
	logic           job_valid;
	logic           job_ready;

	// split the value into digits and count the significant ones
	itoa_conv #(
		.DEC_DIGITS (DEC_DIGITS),
		.HEX_DIGITS (HEX_DIGITS)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	// send sign, padding and digits, most significant first
	itoa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.text      (text)
	);

endmodule

// ----- hw/rtl/itoa_check.sv -----
// ----------------------------------------------------------------------------
// itoa_check: port checker of the integer to ASCII formatter
// Watches the channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module itoa_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          text_valid,
	input logic                          text_ready,
	input logic [itoa_pkg::CHAR_W-1:0]   text_char,
	input logic                          text_last
);

	// hold a stalled character
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_char) && $stable(text_last))
		else $error("stalled character changed");

	// converter goes busy after taking a number
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item ready right after a transaction");

	// only digits, hex letters, space and minus leave the block
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |->
			(text_char >= itoa_pkg::CHAR_ZERO && text_char <= itoa_pkg::CHAR_ZERO + 8'd9) ||
			(text_char >= itoa_pkg::CHAR_LOWER_A && text_char <= itoa_pkg::CHAR_LOWER_A + 8'd5) ||
			(text_char >= itoa_pkg::CHAR_UPPER_A && text_char <= itoa_pkg::CHAR_UPPER_A + 8'd5) ||
			(text_char == itoa_pkg::CHAR_SPACE) || (text_char == itoa_pkg::CHAR_MINUS))
		else $error("unexpected character");

	// a minus sign is never marked as the last character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && (text_char == itoa_pkg::CHAR_MINUS) |-> !text_last)
		else $error("minus marked as last character");

endmodule

bind integer_to_ascii_formatter_core itoa_check u_itoa_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.text_char  (text.out_char),
	.text_last  (text.last)
);
